### design/tlmr_pkg.sv
package tlmr_pkg;

	// Structural constants
	localparam int WINDOW_LENGTH    = 10;
	localparam int STEPS_PER_SAMPLE = 3;
	localparam int SAMPLE_WIDTH     = 24;

	// Fixed field widths
	localparam int DUTY_W    = 16;
	localparam int TARE_W    = 24;
	localparam int TARGET_W  = 16;
	localparam int PCT_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	// Ramp constants
	localparam int DUTY_START    = 3550;
	localparam int CAP_BASE      = 327700;	// 3277 * 100
	localparam int CAP_PER_PCT   = 3277;	// 32.77 * 100
	localparam int DUTY_SCALE    = 100;
	localparam int GRAMS_DIVISOR = 45;

	// Register reset values
	localparam int TARE_RESET   = 0;
	localparam int TARGET_RESET = 400;
	localparam int PCT_RESET    = 90;

	// Derived widths
	localparam int WIDE_IN = (SAMPLE_WIDTH > TARE_W) ? SAMPLE_WIDTH : TARE_W;
	localparam int SUM_W   = SAMPLE_WIDTH + $clog2(WINDOW_LENGTH);
	localparam int CMP_W   = WIDE_IN + $clog2(WINDOW_LENGTH) + 2;
	localparam int CAP_W   = DUTY_W + PCT_W;
	localparam int STEP_W  = $clog2(STEPS_PER_SAMPLE + 1);
	localparam int HIST_N  = WINDOW_LENGTH - 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PCT    = 2'd2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [DUTY_W-1:0]              duty_t;

	typedef enum logic [1:0] {
		REASON_NONE   = 2'd0,
		REASON_THRUST = 2'd1,
		REASON_LIMIT  = 2'd2
	} reason_t;

	// Scaled thresholds, derived from the register values
	typedef struct packed {
		logic signed [CMP_W-1:0] tare_scaled;	// WINDOW_LENGTH * tare
		logic signed [CMP_W-1:0] target_scaled;	// 45 * WINDOW_LENGTH * grams
		logic [CAP_W-1:0]        cap_scaled;	// 100 * duty cap
	} cfg_t;

	// One decided input, handed to the result sequencer
	typedef struct packed {
		duty_t             duty;
		logic [STEP_W-1:0] last_idx;	// beats after the first
		logic              finished;
		reason_t           reason;
	} job_t;

endpackage

### design/tlmr_if.sv
interface tlmr_sample_if;
	import tlmr_pkg::*;

	logic    valid;
	logic    ready;
	sample_t load_sample;

	modport source (output valid, output load_sample, input ready);
	modport sink   (input valid, input load_sample, output ready);
endinterface

interface tlmr_result_if;
	import tlmr_pkg::*;

	logic       valid;
	logic       ready;
	duty_t      duty_value;
	logic       last_of_run;
	logic       finished;
	logic [1:0] stop_reason;

	modport source (output valid, output duty_value, output last_of_run,
		output finished, output stop_reason, input ready);
	modport sink   (input valid, input duty_value, input last_of_run,
		input finished, input stop_reason, output ready);
endinterface

### design/tlmr_cfg.sv
module tlmr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tlmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlmr_pkg::CFG_DAT_W-1:0]     cfg_data,
	output tlmr_pkg::cfg_t                     cfg
);
	import tlmr_pkg::*;

	logic signed [CMP_W-1:0] tare_scaled_q;
	logic signed [CMP_W-1:0] target_scaled_q;
	logic [CAP_W-1:0]        cap_scaled_q;

	logic signed [CMP_W-1:0] tare_in;
	logic [CMP_W-1:0]        target_in;
	logic [CAP_W-1:0]        pct_in;

	assign tare_in   = CMP_W'(signed'(cfg_data[TARE_W-1:0]));
	assign target_in = CMP_W'(cfg_data[TARGET_W-1:0]);
	assign pct_in    = CAP_W'(cfg_data[PCT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_scaled_q   <= CMP_W'(WINDOW_LENGTH * TARE_RESET);
			target_scaled_q <= CMP_W'(GRAMS_DIVISOR * WINDOW_LENGTH * TARGET_RESET);
			cap_scaled_q    <= CAP_W'(CAP_BASE + CAP_PER_PCT * PCT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARE:   tare_scaled_q <= tare_in * CMP_W'(WINDOW_LENGTH);
				CFG_TARGET: target_scaled_q <=
					signed'(target_in * CMP_W'(GRAMS_DIVISOR * WINDOW_LENGTH));
				CFG_PCT:    cap_scaled_q <=
					CAP_W'(CAP_BASE) + pct_in * CAP_W'(CAP_PER_PCT);
				default: ;	// unmapped index: write dropped
			endcase
		end
	end

	assign cfg.tare_scaled   = tare_scaled_q;
	assign cfg.target_scaled = target_scaled_q;
	assign cfg.cap_scaled    = cap_scaled_q;
endmodule

### design/tlmr_core.sv
module tlmr_core (
	input  logic            clk,
	input  logic            arst_n,
	input  tlmr_pkg::cfg_t  cfg,
	tlmr_sample_if.sink     samples,
	input  logic            emit_free,
	output logic            job_load,
	output tlmr_pkg::job_t  job
);
	import tlmr_pkg::*;

	logic                     valid_s1;
	sample_t                  sample_s1;
	duty_t                    duty_q;
	logic                     done_q;
	reason_t                  reason_q;
	logic signed [SUM_W-1:0]  sum_q;
	sample_t                  hist_q [HIST_N];

	logic                     advance;
	logic signed [SUM_W-1:0]  total;
	logic signed [CMP_W-1:0]  net;
	logic [CAP_W-1:0]         duty_x100;
	logic                     limit_hit;
	logic                     thrust_hit;

	assign advance       = valid_s1 && emit_free;
	assign samples.ready = !valid_s1 || emit_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.load_sample;
		end
	end

	// decision
	assign duty_x100  = CAP_W'(duty_q) * CAP_W'(DUTY_SCALE);
	assign limit_hit  = duty_x100 >= cfg.cap_scaled;
	assign total      = sum_q + SUM_W'(sample_s1);
	assign net        = CMP_W'(total) - cfg.tare_scaled;
	assign thrust_hit = net >= cfg.target_scaled;

	always_comb begin
		job.duty     = duty_q;
		job.last_idx = '0;
		job.finished = 1'b1;
		job.reason   = reason_q;
		if (!done_q) begin
			if (limit_hit) begin
				job.reason = REASON_LIMIT;
			end else if (thrust_hit) begin
				job.reason = REASON_THRUST;
			end else begin
				job.finished = 1'b0;
				job.reason   = REASON_NONE;
				job.last_idx = STEP_W'(STEPS_PER_SAMPLE - 1);
			end
		end
	end

	assign job_load = advance;

	// ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q   <= DUTY_W'(DUTY_START);
			done_q   <= 1'b0;
			reason_q <= REASON_NONE;
			sum_q    <= '0;
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
		end else if (advance && !done_q) begin
			if (limit_hit) begin
				done_q   <= 1'b1;
				reason_q <= REASON_LIMIT;
			end else begin
				// running sum of the held samples
				sum_q     <= total - SUM_W'(hist_q[HIST_N-1]);
				hist_q[0] <= sample_s1;
				for (int i = 1; i < HIST_N; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				if (thrust_hit) begin
					done_q   <= 1'b1;
					reason_q <= REASON_THRUST;
				end else begin
					duty_q <= duty_q + DUTY_W'(STEPS_PER_SAMPLE);
				end
			end
		end
	end
endmodule

### design/tlmr_emit.sv
module tlmr_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_load,
	input  tlmr_pkg::job_t  job,
	output logic            emit_free,
	tlmr_result_if.source   results
);
	import tlmr_pkg::*;

	logic              busy_q;
	duty_t             duty_q;
	logic [STEP_W-1:0] remain_q;
	logic              fin_q;
	reason_t           reason_q;
	logic              fire;

	assign fire      = busy_q && results.ready;
	assign emit_free = !busy_q || (results.ready && remain_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (job_load) begin
			busy_q <= 1'b1;
		end else if (fire && remain_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			duty_q   <= job.duty;
			remain_q <= job.last_idx;
			fin_q    <= job.finished;
			reason_q <= job.reason;
		end else if (fire && remain_q != '0) begin
			duty_q   <= duty_q + DUTY_W'(1);
			remain_q <= remain_q - STEP_W'(1);
		end
	end

	assign results.valid       = busy_q;
	assign results.duty_value  = duty_q;
	assign results.last_of_run = (remain_q == '0);
	assign results.finished    = fin_q;
	assign results.stop_reason = reason_q;
endmodule

### design/thrust_limited_motor_ramp.sv
// Thrust-limited motor ramp. Each load-cell sample beat on samples steps a PWM duty
// ramp that starts at 3550: while ramping, a sample gives three duty beats (duty,
// duty+1, duty+2, the last flagged last_of_run) and the duty moves on by three. The
// ramp stops for good on the speed cap (100*duty >= 327700 + 3277*percent, sample
// discarded) or once the ten-sample window sum, less ten times the tare, reaches
// 450 times the gram target; that sample and every later one give a single
// finished beat that holds the final duty and the stop reason. Only arst_n
// restarts the ramp. A sample passes through the input register and then leaves
// one to three beats in the result register, which gives one result beat per
// cycle while results.ready is high and so paces the samples. The next sample
// is taken while results still drain. Register writes take effect in the next
// cycle; the user must make them only while idle; the block does not enforce it.
module thrust_limited_motor_ramp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tlmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlmr_pkg::CFG_DAT_W-1:0]  cfg_data,
	tlmr_sample_if.sink                     samples,
	tlmr_result_if.source                   results
);
	import tlmr_pkg::*;

	cfg_t cfg;		// scaled thresholds
	job_t job;		// decided sample, one to three beats
	logic job_load;
	logic emit_free;	// result register can take a new job this cycle

	// register file; scaling by the window, divisor and cap constants done at write
	tlmr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register, cap and thrust compares, window and duty state
	tlmr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.samples   (samples),
		.emit_free (emit_free),
		.job_load  (job_load),
		.job       (job)
	);

	// result register, steps out the beats of one job
	tlmr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_load  (job_load),
		.job       (job),
		.emit_free (emit_free),
		.results   (results)
	);
endmodule
